>>> src/tsqm_pkg.sv
package tsqm_pkg;

   // Field widths.
   localparam int RAW_W     = 16;
   localparam int DIFF_W    = RAW_W + 1;
   localparam int LAST_W    = 12;
   localparam int NUM_W     = DIFF_W + LAST_W;
   localparam int QUO_W     = LAST_W;
   localparam int CSR_IDX_W = 3;

   localparam int PIXEL_BITS_DEFAULT = 12;

   // Largest difference between the two X readings that still counts as stable.
   localparam logic signed [DIFF_W-1:0] STABLE_SPAN = 17'sd500;

   // Register values after reset.
   localparam logic signed [RAW_W-1:0] THRESH_RESET = 16'sd1000;
   localparam logic signed [RAW_W-1:0] CAL_MIN_RESET = 16'sd0;
   localparam logic signed [RAW_W-1:0] CAL_MAX_RESET = 16'sd32767;
   localparam logic [LAST_W-1:0] X_LAST_RESET = 12'd239;
   localparam logic [LAST_W-1:0] Y_LAST_RESET = 12'd319;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESS_THRESHOLD = 3'd0,
      CSR_X_CAL_MIN       = 3'd1,
      CSR_X_CAL_MAX       = 3'd2,
      CSR_Y_CAL_MIN       = 3'd3,
      CSR_Y_CAL_MAX       = 3'd4,
      CSR_X_PIXEL_LAST    = 3'd5,
      CSR_Y_PIXEL_LAST    = 3'd6
   } tsqm_csr_idx_type;

   // Decisions made at the qualify stage, carried down the pipeline.
   typedef struct packed {
      logic             touched;
      logic             x_low;
      logic             x_high;
      logic             y_low;
      logic             y_high;
      logic [RAW_W-1:0] x_raw;
      logic [RAW_W-1:0] y_raw;
   } tsqm_ctl_type;

   // One axis inside the restoring divider.
   typedef struct packed {
      logic [NUM_W-1:0]  rem;
      logic [DIFF_W-1:0] den;
      logic [QUO_W-1:0]  quo;
   } tsqm_div_type;

   // One restoring step: try the divisor shifted up by sh, shift in one quotient bit.
   function automatic tsqm_div_type div_step(tsqm_div_type a, int unsigned sh);
      tsqm_div_type     r;
      logic [NUM_W-1:0] trial;
      r     = a;
      trial = NUM_W'(a.den) << sh;
      if (a.rem >= trial) begin
         r.rem = a.rem - trial;
         r.quo = {a.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.quo = {a.quo[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

>>> src/tsqm_if.sv
// Input channel: one set of panel readings.
interface tsqm_req_if;
   import tsqm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] x_first;
   logic signed [RAW_W-1:0] y_sample;
   logic signed [RAW_W-1:0] x_second;
   modport source (output valid, x_first, y_sample, x_second, input ready);
   modport sink (input valid, x_first, y_sample, x_second, output ready);
endinterface

// Result channel: qualified press and mapped coordinates.
interface tsqm_rsp_if #(parameter int PIXEL_BITS = tsqm_pkg::PIXEL_BITS_DEFAULT);
   import tsqm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    touched;
   logic [PIXEL_BITS-1:0]   x_pixel;
   logic [PIXEL_BITS-1:0]   y_pixel;
   logic signed [RAW_W-1:0] x_raw_out;
   logic signed [RAW_W-1:0] y_raw_out;
   modport source (output valid, touched, x_pixel, y_pixel, x_raw_out, y_raw_out,
                   input ready);
   modport sink (input valid, touched, x_pixel, y_pixel, x_raw_out, y_raw_out,
                 output ready);
endinterface

// Configuration write channel.
interface tsqm_csr_if;
   import tsqm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [RAW_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/touch_sample_qualify_and_map.sv
// A result passes through the input register, qualify stage, multiply stage, 12 divider
// stages and the output register.
// Throughput: one sample set per cycle while the skid register is empty; the 12-stage
// divider retires one quotient bit per stage and every stage takes a new item each cycle.
// A skid register behind the output takes one item on a stall, keeping input open.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
module touch_sample_qualify_and_map #(
   parameter int PIXEL_BITS = tsqm_pkg::PIXEL_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   tsqm_req_if.sink    req_ch,
   tsqm_rsp_if.source  rsp_ch,
   tsqm_csr_if.sink    csr_ch
);
   import tsqm_pkg::*;

   localparam int DIV_STAGES = QUO_W;

   typedef struct packed {
      logic                  touched;
      logic [PIXEL_BITS-1:0] x_pixel;
      logic [PIXEL_BITS-1:0] y_pixel;
      logic [RAW_W-1:0]      x_raw;
      logic [RAW_W-1:0]      y_raw;
   } rsp_type;

   // Configuration registers.
   logic signed [RAW_W-1:0] thresh_ff;
   logic signed [RAW_W-1:0] x_min_ff;
   logic signed [RAW_W-1:0] x_max_ff;
   logic signed [RAW_W-1:0] y_min_ff;
   logic signed [RAW_W-1:0] y_max_ff;
   logic [LAST_W-1:0]       x_last_ff;
   logic [LAST_W-1:0]       y_last_ff;

   // Pipeline.
   logic                    en;
   logic                    accept;
   logic                    s0_v_ff;
   logic signed [RAW_W-1:0] s0_x1_ff;
   logic signed [RAW_W-1:0] s0_y_ff;
   logic signed [RAW_W-1:0] s0_x2_ff;

   logic                    s1_v_ff;
   tsqm_ctl_type            s1_ctl_in, s1_ctl_ff;
   logic [DIFF_W-1:0]       s1_rx_in, s1_rx_ff;
   logic [DIFF_W-1:0]       s1_dx_in, s1_dx_ff;
   logic [DIFF_W-1:0]       s1_ry_in, s1_ry_ff;
   logic [DIFF_W-1:0]       s1_dy_in, s1_dy_ff;

   logic                    s2_v_ff;
   tsqm_ctl_type            s2_ctl_ff;
   tsqm_div_type            s2_x_in, s2_x_ff;
   tsqm_div_type            s2_y_in, s2_y_ff;

   logic [DIV_STAGES-1:0]   dv_v_ff;
   tsqm_ctl_type            dv_ctl_ff [DIV_STAGES];
   tsqm_div_type            dv_x_in [DIV_STAGES];
   tsqm_div_type            dv_x_ff [DIV_STAGES];
   tsqm_div_type            dv_y_in [DIV_STAGES];
   tsqm_div_type            dv_y_ff [DIV_STAGES];

   // Output and skid registers.
   logic                    out_v_in, out_v_ff;
   rsp_type                 out_in, out_ff;
   logic                    skid_v_in, skid_v_ff;
   rsp_type                 skid_in, skid_ff;
   rsp_type                 tail_res;
   logic                    tail_fire;
   logic                    out_free;

   // Configuration writes are always taken; unknown indexes are dropped.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         x_min_ff  <= CAL_MIN_RESET;
         x_max_ff  <= CAL_MAX_RESET;
         y_min_ff  <= CAL_MIN_RESET;
         y_max_ff  <= CAL_MAX_RESET;
         x_last_ff <= X_LAST_RESET;
         y_last_ff <= Y_LAST_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_PRESS_THRESHOLD: thresh_ff <= csr_ch.data;
            CSR_X_CAL_MIN:       x_min_ff  <= csr_ch.data;
            CSR_X_CAL_MAX:       x_max_ff  <= csr_ch.data;
            CSR_Y_CAL_MIN:       y_min_ff  <= csr_ch.data;
            CSR_Y_CAL_MAX:       y_max_ff  <= csr_ch.data;
            CSR_X_PIXEL_LAST:    x_last_ff <= csr_ch.data[LAST_W-1:0];
            CSR_Y_PIXEL_LAST:    y_last_ff <= csr_ch.data[LAST_W-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together unless the skid register is occupied.
   assign en            = !skid_v_ff;
   assign req_ch.ready  = en;
   assign accept        = req_ch.valid && en;

   // Qualify stage: press decision, clamp flags and the offsets fed to the multiplier.
   always_comb begin
      logic signed [DIFF_W-1:0] xdiff;
      logic                     early;
      logic                     unstable;
      logic                     released;
      xdiff    = $signed({s0_x1_ff[RAW_W-1], s0_x1_ff}) - $signed({s0_x2_ff[RAW_W-1], s0_x2_ff});
      early    = s0_x1_ff < thresh_ff;
      unstable = (xdiff > STABLE_SPAN) || (xdiff < -STABLE_SPAN);
      released = s0_x2_ff < thresh_ff;

      s1_ctl_in.touched = !early && !unstable && !released;
      s1_ctl_in.x_low   = s0_x2_ff <= x_min_ff;
      s1_ctl_in.x_high  = s0_x2_ff >= x_max_ff;
      s1_ctl_in.y_low   = s0_y_ff <= y_min_ff;
      s1_ctl_in.y_high  = s0_y_ff >= y_max_ff;
      s1_ctl_in.x_raw   = early ? s0_x1_ff : s0_x2_ff;
      s1_ctl_in.y_raw   = early ? '0 : s0_y_ff;

      s1_rx_in = {s0_x2_ff[RAW_W-1], s0_x2_ff} - {x_min_ff[RAW_W-1], x_min_ff};
      s1_dx_in = {x_max_ff[RAW_W-1], x_max_ff} - {x_min_ff[RAW_W-1], x_min_ff};
      s1_ry_in = {s0_y_ff[RAW_W-1], s0_y_ff} - {y_min_ff[RAW_W-1], y_min_ff};
      s1_dy_in = {y_max_ff[RAW_W-1], y_max_ff} - {y_min_ff[RAW_W-1], y_min_ff};
   end

   // Multiply stage: numerator of the linear map for each axis.
   always_comb begin
      s2_x_in.rem = NUM_W'(s1_rx_ff) * NUM_W'(x_last_ff);
      s2_x_in.den = s1_dx_ff;
      s2_x_in.quo = '0;
      s2_y_in.rem = NUM_W'(s1_ry_ff) * NUM_W'(y_last_ff);
      s2_y_in.den = s1_dy_ff;
      s2_y_in.quo = '0;
   end

   // Divider stages, most significant quotient bit first.
   always_comb begin
      dv_x_in[0] = div_step(s2_x_ff, QUO_W - 1);
      dv_y_in[0] = div_step(s2_y_ff, QUO_W - 1);
      for (int k = 1; k < DIV_STAGES; k++) begin
         dv_x_in[k] = div_step(dv_x_ff[k-1], QUO_W - 1 - k);
         dv_y_in[k] = div_step(dv_y_ff[k-1], QUO_W - 1 - k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         dv_v_ff <= '0;
      end else if (en) begin
         s0_v_ff <= accept;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         dv_v_ff <= {dv_v_ff[DIV_STAGES-2:0], s2_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x1_ff     <= req_ch.x_first;
         s0_y_ff      <= req_ch.y_sample;
         s0_x2_ff     <= req_ch.x_second;
         s1_ctl_ff    <= s1_ctl_in;
         s1_rx_ff     <= s1_rx_in;
         s1_dx_ff     <= s1_dx_in;
         s1_ry_ff     <= s1_ry_in;
         s1_dy_ff     <= s1_dy_in;
         s2_ctl_ff    <= s1_ctl_ff;
         s2_x_ff      <= s2_x_in;
         s2_y_ff      <= s2_y_in;
         dv_ctl_ff[0] <= s2_ctl_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            dv_ctl_ff[k] <= dv_ctl_ff[k-1];
         end
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_x_ff[k] <= dv_x_in[k];
            dv_y_ff[k] <= dv_y_in[k];
         end
      end
   end

   // Final selection: clamp to the ends of the range, zero when rejected.
   always_comb begin
      tsqm_ctl_type      c;
      logic [LAST_W-1:0] xv;
      logic [LAST_W-1:0] yv;
      c  = dv_ctl_ff[DIV_STAGES-1];
      xv = c.x_low ? '0 : (c.x_high ? x_last_ff : dv_x_ff[DIV_STAGES-1].quo);
      yv = c.y_low ? '0 : (c.y_high ? y_last_ff : dv_y_ff[DIV_STAGES-1].quo);
      tail_res.touched = c.touched;
      tail_res.x_pixel = c.touched ? PIXEL_BITS'(xv) : '0;
      tail_res.y_pixel = c.touched ? PIXEL_BITS'(yv) : '0;
      tail_res.x_raw   = c.x_raw;
      tail_res.y_raw   = c.y_raw;
   end

   // Output register with a skid stage behind it.
   assign out_free  = !out_v_ff || rsp_ch.ready;
   assign tail_fire = en && dv_v_ff[DIV_STAGES-1];

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (out_free) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = tail_fire;
            out_in   = tail_res;
         end
      end else if (tail_fire) begin
         skid_v_in = 1'b1;
         skid_in   = tail_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid     = out_v_ff;
   assign rsp_ch.touched   = out_ff.touched;
   assign rsp_ch.x_pixel   = out_ff.x_pixel;
   assign rsp_ch.y_pixel   = out_ff.y_pixel;
   assign rsp_ch.x_raw_out = out_ff.x_raw;
   assign rsp_ch.y_raw_out = out_ff.y_raw;

   // The skid register only holds an item while the output register is full.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register valid while output register empty");

   // The skid register fills only when the output was blocked in the cycle before.
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_ch.ready))
      else $error("skid register filled without an output stall");

   // While the pipeline is stalled no item moves, appears or vanishes.
   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable({s0_v_ff, s1_v_ff, s2_v_ff, dv_v_ff}))
      else $error("pipeline valid bits changed during a stall");

   // A rejected set never carries coordinates.
   a_reject_zero_pixels: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_ff.touched) |-> (out_ff.x_pixel == '0 && out_ff.y_pixel == '0))
      else $error("rejected set with nonzero coordinates");

endmodule
